### hw/rtl/iahp_pkg.sv
`timescale 1ns / 1ps

package iahp_pkg;

    // coefficients are signed Q2.22
    localparam int COEF_W    = 24;
    localparam int COEF_FRAC = 22;
    localparam int COEF_COUNT = 12;

    typedef logic signed [COEF_W-1:0] coef_t;

    // status of the serial multiplier as seen by the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } mult_stat_t;

    // sections 0..5 feed the first branch, 6..11 the second;
    // sections past the table use zero
    function automatic coef_t coef_at(input logic [31:0] k);
        coef_t c;
        case (k)
            32'd0:   c = -24'sd4191070;
            32'd1:   c = -24'sd4169804;
            32'd2:   c = -24'sd4095470;
            32'd3:   c = -24'sd3811414;
            32'd4:   c = -24'sd2843468;
            32'd5:   c = -24'sd332231;
            32'd6:   c = -24'sd4183093;
            32'd7:   c = -24'sd4144697;
            32'd8:   c = -24'sd3998702;
            32'd9:   c = -24'sd3461123;
            32'd10:  c = -24'sd1841514;
            32'd11:  c = 24'sd2075998;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

### hw/rtl/iahp_serial_mult.sv
`timescale 1ns / 1ps

// Bit-serial signed multiply, one coefficient bit per cycle (LSB first),
// followed by rounding, the x_prev add and saturation on the final product.
module iahp_serial_mult #(
    parameter int SAMPLE_WIDTH = 24
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic signed [SAMPLE_WIDTH:0]   diff,
    input  iahp_pkg::coef_t                coef,
    input  logic signed [SAMPLE_WIDTH-1:0] prev_in,
    output iahp_pkg::mult_stat_t           stat,
    output logic signed [SAMPLE_WIDTH-1:0] y
);
    localparam int W   = SAMPLE_WIDTH;
    localparam int DW  = W + 1;
    localparam int HW  = W + 2;
    localparam int CW  = iahp_pkg::COEF_W;
    localparam int FR  = iahp_pkg::COEF_FRAC;
    localparam int PW  = HW + CW;
    localparam int QW  = PW - FR;
    localparam int SW  = QW + 1;
    localparam int CNW = $clog2(CW);

    logic signed [DW-1:0]  diff_reg;
    logic signed [HW-1:0]  hi_reg, hi_next;
    logic [CW-1:0]         lo_reg, lo_next;
    logic [CW-1:0]         c_reg, c_next;
    logic [CNW-1:0]        cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;

    logic signed [HW-1:0]  dext;
    logic signed [HW-1:0]  addend;
    logic signed [HW-1:0]  sum;
    logic                  last;
    logic [PW-1:0]         prod;
    logic signed [SW-1:0]  s;

    assign last = (cnt_reg == CNW'(CW - 1));
    assign dext = {diff_reg[DW-1], diff_reg};

    always_comb begin
        // sign bit of the multiplier carries negative weight
        if (c_reg[0]) begin
            addend = last ? -dext : dext;
        end else begin
            addend = '0;
        end
        sum = hi_reg + addend;
    end

    always_comb begin
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        c_next    = c_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            hi_next   = '0;
            c_next    = coef;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            hi_next  = sum >>> 1;
            lo_next  = {sum[0], lo_reg[CW-1:1]};
            c_next   = {1'b0, c_reg[CW-1:1]};
            cnt_next = cnt_reg + 1'b1;
            if (last) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            diff_reg <= diff;
        end
        hi_reg <= hi_next;
        lo_reg <= lo_next;
        c_reg  <= c_next;
    end

    // round half up: floor(p / 2^FR) plus bit FR-1, then add x_prev
    assign prod = {hi_reg, lo_reg};
    assign s = {prod[PW-1], prod[PW-1:FR]}
             + {{(SW - W){prev_in[W-1]}}, prev_in}
             + SW'(prod[FR-1]);

    always_comb begin
        if (s[SW-1:W-1] != {(SW - W + 1){s[SW-1]}}) begin
            y = s[SW-1] ? {1'b1, {(W - 1){1'b0}}} : {1'b0, {(W - 1){1'b1}}};
        end else begin
            y = s[W-1:0];
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

### hw/rtl/iahp_sec_mem.sv
`timescale 1ns / 1ps

// Per-section x_prev / y_prev storage, cleared by reset.
module iahp_sec_mem #(
    parameter int SAMPLE_WIDTH = 24,
    parameter int DEPTH        = 12
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           wr_en,
    input  logic [$clog2(DEPTH)-1:0]       addr,
    input  logic signed [SAMPLE_WIDTH-1:0] wr_in,
    input  logic signed [SAMPLE_WIDTH-1:0] wr_out,
    output logic signed [SAMPLE_WIDTH-1:0] rd_in,
    output logic signed [SAMPLE_WIDTH-1:0] rd_out
);
    logic signed [SAMPLE_WIDTH-1:0] prev_in_reg  [DEPTH];
    logic signed [SAMPLE_WIDTH-1:0] prev_out_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DEPTH; i++) begin
                prev_in_reg[i]  <= '0;
                prev_out_reg[i] <= '0;
            end
        end else if (wr_en) begin
            prev_in_reg[addr]  <= wr_in;
            prev_out_reg[addr] <= wr_out;
        end
    end

    assign rd_in  = prev_in_reg[addr];
    assign rd_out = prev_out_reg[addr];

endmodule

### hw/rtl/iir_allpass_hilbert_pair.sv
`timescale 1ns / 1ps

// Hilbert pair: each input word runs through two chains of first-order
// allpass sections (y = c*(x - y_prev) + x_prev, Q1.23 samples, Q2.22
// coefficients, saturating); the two chain outputs leave together as one
// output word. All sections share one bit-serial multiplier that takes one
// coefficient bit per cycle, so the sections of both chains run one after
// another for each word.
// A new word is taken while the previous result still waits in the output
// register. No warm-up after reset: section memories clear at once.
module iir_allpass_hilbert_pair #(
    parameter int SECTIONS_PER_BRANCH = 6,
    parameter int SAMPLE_WIDTH        = 24
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] s_sample_in,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic signed [SAMPLE_WIDTH-1:0] m_phase_a_out,
    output logic signed [SAMPLE_WIDTH-1:0] m_phase_b_out
);
    localparam int W     = SAMPLE_WIDTH;
    localparam int DEPTH = 2 * SECTIONS_PER_BRANCH;
    localparam int KW    = $clog2(DEPTH);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_START = 4'b0010,
        ST_MULT  = 4'b0100,
        ST_OUT   = 4'b1000
    } state_t;

    state_t                state_reg, state_next;
    logic [KW-1:0]         k_reg, k_next;
    logic signed [W-1:0]   samp_reg, samp_next;
    logic signed [W-1:0]   x_reg, x_next;
    logic signed [W-1:0]   a_reg, a_next;
    logic signed [W-1:0]   b_reg, b_next;
    logic                  m_valid_reg, m_valid_next;
    logic signed [W-1:0]   out_a_reg, out_a_next;
    logic signed [W-1:0]   out_b_reg, out_b_next;

    logic                  wr_en;
    logic                  start;
    logic signed [W-1:0]   rd_in, rd_out;
    logic signed [W:0]     diff;
    logic signed [W-1:0]   y;
    iahp_pkg::mult_stat_t  mstat;
    iahp_pkg::coef_t       coef;

    assign diff = {x_reg[W-1], x_reg} - {rd_out[W-1], rd_out};
    assign coef = iahp_pkg::coef_at(32'(k_reg));

    iahp_sec_mem #(
        .SAMPLE_WIDTH (W),
        .DEPTH        (DEPTH)
    ) u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (wr_en),
        .addr    (k_reg),
        .wr_in   (x_reg),
        .wr_out  (y),
        .rd_in   (rd_in),
        .rd_out  (rd_out)
    );

    iahp_serial_mult #(
        .SAMPLE_WIDTH (W)
    ) u_mult (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start),
        .diff    (diff),
        .coef    (coef),
        .prev_in (rd_in),
        .stat    (mstat),
        .y       (y)
    );

    always_comb begin
        state_next   = state_reg;
        k_next       = k_reg;
        samp_next    = samp_reg;
        x_next       = x_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        m_valid_next = m_valid_reg;
        out_a_next   = out_a_reg;
        out_b_next   = out_b_reg;
        wr_en        = 1'b0;
        start        = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    samp_next  = s_sample_in;
                    x_next     = s_sample_in;
                    k_next     = '0;
                    state_next = ST_START;
                end
            end
            ST_START: begin
                start      = 1'b1;
                state_next = ST_MULT;
            end
            ST_MULT: begin
                if (mstat.done) begin
                    wr_en = 1'b1;
                    if (k_reg == KW'(DEPTH - 1)) begin
                        b_next     = y;
                        state_next = ST_OUT;
                    end else begin
                        // second branch restarts from the input word
                        if (k_reg == KW'(SECTIONS_PER_BRANCH - 1)) begin
                            a_next = y;
                            x_next = samp_reg;
                        end else begin
                            x_next = y;
                        end
                        k_next     = k_reg + 1'b1;
                        state_next = ST_START;
                    end
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    out_a_next   = a_reg;
                    out_b_next   = b_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            k_reg       <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            k_reg       <= k_next;
        end
    end

    always_ff @(posedge aclk) begin
        samp_reg  <= samp_next;
        x_reg     <= x_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        out_a_reg <= out_a_next;
        out_b_reg <= out_b_next;
    end

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_phase_a_out = out_a_reg;
    assign m_phase_b_out = out_b_reg;

endmodule

### hw/rtl/iahp_checker.sv
`timescale 1ns / 1ps

module iahp_checker #(
    parameter int SAMPLE_WIDTH = 24
) (
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    s_valid,
    input logic                    s_ready,
    input logic                    m_valid,
    input logic                    m_ready,
    input logic [SAMPLE_WIDTH-1:0] m_phase_a_out,
    input logic [SAMPLE_WIDTH-1:0] m_phase_b_out
);

    // no result word right out of reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_phase_a_out)
                                && $stable(m_phase_b_out))
        else $error("stalled result word changed");

    // one word in flight: input closes once a word is taken
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input still open after accepting a word");

    // a result appears only at the end of processing, never from idle
    a_result_from_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(s_ready))
        else $error("result appeared without processing");

    // the input reopens only after the previous word's result is posted
    a_ready_after_result: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(s_ready) |-> m_valid)
        else $error("input reopened before result was posted");

endmodule

bind iir_allpass_hilbert_pair iahp_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_iahp_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_phase_a_out (m_phase_a_out),
    .m_phase_b_out (m_phase_b_out)
);
